>>> sv/x86alu_pkg.sv
`timescale 1ns / 1ps
// Shared types and constants for the 16-bit x86 ALU with flags.
package x86alu_pkg;

    // Operation codes of the request.
    localparam logic [4:0] OP_ADD  = 5'd0;
    localparam logic [4:0] OP_OR   = 5'd1;
    localparam logic [4:0] OP_ADC  = 5'd2;
    localparam logic [4:0] OP_SBB  = 5'd3;
    localparam logic [4:0] OP_AND  = 5'd4;
    localparam logic [4:0] OP_SUB  = 5'd5;
    localparam logic [4:0] OP_XOR  = 5'd6;
    localparam logic [4:0] OP_CMP  = 5'd7;
    localparam logic [4:0] OP_TEST = 5'd8;
    localparam logic [4:0] OP_ROL  = 5'd9;
    localparam logic [4:0] OP_ROR  = 5'd10;
    localparam logic [4:0] OP_RCL  = 5'd11;
    localparam logic [4:0] OP_RCR  = 5'd12;
    localparam logic [4:0] OP_SHL  = 5'd13;
    localparam logic [4:0] OP_SHR  = 5'd14;
    localparam logic [4:0] OP_SAL  = 5'd15;
    localparam logic [4:0] OP_SAR  = 5'd16;
    localparam logic [4:0] OP_INC  = 5'd17;
    localparam logic [4:0] OP_DEC  = 5'd18;
    localparam logic [4:0] OP_NEG  = 5'd19;
    localparam logic [4:0] OP_NOT  = 5'd20;
    localparam logic [4:0] OP_MUL  = 5'd21;
    localparam logic [4:0] OP_IMUL = 5'd22;
    localparam logic [4:0] OP_DIV  = 5'd23;
    localparam logic [4:0] OP_IDIV = 5'd24;

    // ALU sub-operations (low three bits of the ALU operation codes).
    localparam logic [2:0] ALU_ADD = 3'd0;
    localparam logic [2:0] ALU_OR  = 3'd1;
    localparam logic [2:0] ALU_ADC = 3'd2;
    localparam logic [2:0] ALU_SBB = 3'd3;
    localparam logic [2:0] ALU_AND = 3'd4;
    localparam logic [2:0] ALU_SUB = 3'd5;
    localparam logic [2:0] ALU_XOR = 3'd6;
    localparam logic [2:0] ALU_CMP = 3'd7;

    // Shift and rotate sub-operations.
    localparam logic [2:0] SH_ROL = 3'd0;
    localparam logic [2:0] SH_ROR = 3'd1;
    localparam logic [2:0] SH_RCL = 3'd2;
    localparam logic [2:0] SH_RCR = 3'd3;
    localparam logic [2:0] SH_SHL = 3'd4;
    localparam logic [2:0] SH_SHR = 3'd5;
    localparam logic [2:0] SH_SAL = 3'd6;
    localparam logic [2:0] SH_SAR = 3'd7;

    // Flag bit positions.
    localparam int FLAG_CF = 0;
    localparam int FLAG_PF = 2;
    localparam int FLAG_AF = 4;
    localparam int FLAG_ZF = 6;
    localparam int FLAG_SF = 7;
    localparam int FLAG_OF = 11;

    // One quotient bit is produced per divider stage.
    localparam int DIV_STEPS = 32;

    typedef enum logic [2:0] {
        CLS_ALU,
        CLS_SHIFT,
        CLS_INCDEC,
        CLS_NEG,
        CLS_NOT,
        CLS_MUL,
        CLS_DIV,
        CLS_BAD
    } t_cls;

    typedef struct packed {
        logic [4:0]  operation;
        logic        word_size;
        logic [15:0] operand_a;
        logic [15:0] operand_b;
        logic [15:0] dividend_high;
        logic [7:0]  shift_count;
        logic [15:0] flags_in;
    } t_in_item;

    typedef struct packed {
        logic [15:0] result;
        logic [15:0] result_high;
        logic [15:0] flags_out;
        logic        divide_fault;
        logic        write_back;
    } t_out_item;

    // Classified request as it waits between front and back.
    typedef struct packed {
        t_cls        cls;
        logic [2:0]  kind;
        logic        word;
        logic [15:0] a;
        logic [15:0] b;
        logic [15:0] ax;
        logic [15:0] dx;
        logic [4:0]  cnt;
        logic [15:0] flags;
        logic        wb;
        logic        msgn;
        logic        dzero;
        logic        qneg;
        logic        rneg;
        logic [31:0] dnum;
        logic [15:0] dden;
    } t_cmd;

    // Results of the execute stage that ride alongside the divider.
    typedef struct packed {
        t_cls        cls;
        logic        word;
        logic        msgn;
        logic        qneg;
        logic        rneg;
        logic        fault;
        logic        wb;
        logic [15:0] res;
        logic [15:0] hi;
        logic [15:0] flags;
        logic [31:0] prod;
    } t_side;

    // Divider working state: partial remainder, dividend/quotient, divisor.
    typedef struct packed {
        logic [15:0] rem;
        logic [31:0] num;
        logic [15:0] den;
    } t_div;

endpackage

>>> sv/x86_16bit_alu_flags_core.sv
`timescale 1ns / 1ps
// Top level of the 16-bit x86 ALU with flags: front end, queue and back end.
//
//  Channel   Handshake            Payload    Direction
//  request   push / full          i_req      in
//  result    pop / empty          o_res      out
//
// One request is accepted per cycle while the queue is not full, and one result leaves per
// cycle while pop is held high. Every accepted request passes through the queue, the
// execute register and the 32-stage pipelined divider before the output register, so
// results stay in order. Reset is synchronous and empties the queue and the pipeline.
// When pop is held low while a result waits at the output, the whole back end holds,
// and the queue keeps taking requests until it is full.
module x86_16bit_alu_flags_core import x86alu_pkg::*; #(
    parameter int QUEUE_DEPTH = 4
) (
    input  logic      i_clk,
    input  logic      i_rst_n,
    input  logic      push,
    output logic      full,
    input  t_in_item  i_req,
    output logic      empty,
    input  logic      pop,
    output t_out_item o_res
);

    t_cmd front_cmd;
    t_cmd head_cmd;
    logic q_empty;
    logic take;

    x86alu_front u_front (
        .i_req (i_req),
        .o_cmd (front_cmd)
    );

    x86alu_queue #(
        .DEPTH (QUEUE_DEPTH)
    ) u_queue (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_wr    (push),
        .i_wdata (front_cmd),
        .o_full  (full),
        .i_rd    (take),
        .o_rdata (head_cmd),
        .o_empty (q_empty)
    );

    x86alu_back u_back (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_valid (!q_empty),
        .i_cmd   (head_cmd),
        .o_take  (take),
        .i_pop   (pop),
        .o_res   (o_res),
        .o_empty (empty)
    );

endmodule

>>> sv/x86alu_front.sv
`timescale 1ns / 1ps
// Front end: decodes a request into an operation class and prepares operands.
module x86alu_front import x86alu_pkg::*; (
    input  t_in_item i_req,
    output t_cmd     o_cmd
);

    logic [4:0]  opc;
    logic        w;
    logic [15:0] am;
    logic [15:0] bm;
    logic        sdiv;
    logic        nneg;
    logic        dneg;
    logic [31:0] n32;
    logic [31:0] neg32;
    logic [15:0] negax;
    logic [15:0] negb;
    logic [7:0]  negb8;

    always_comb begin
        opc   = i_req.operation;
        w     = i_req.word_size;
        am    = w ? i_req.operand_a : {8'h00, i_req.operand_a[7:0]};
        bm    = w ? i_req.operand_b : {8'h00, i_req.operand_b[7:0]};
        sdiv  = (opc == OP_IDIV);
        n32   = w ? {i_req.dividend_high, i_req.operand_a} : {16'h0000, i_req.operand_a};
        neg32 = 32'd0 - n32;
        negax = 16'd0 - i_req.operand_a;
        negb  = 16'd0 - bm;
        negb8 = 8'd0 - bm[7:0];
        nneg  = sdiv & (w ? i_req.dividend_high[15] : i_req.operand_a[15]);
        dneg  = sdiv & (w ? bm[15] : bm[7]);

        o_cmd       = '0;
        o_cmd.word  = w;
        o_cmd.a     = am;
        o_cmd.b     = bm;
        o_cmd.ax    = i_req.operand_a;
        o_cmd.dx    = i_req.dividend_high;
        o_cmd.cnt   = i_req.shift_count[4:0];
        o_cmd.flags = i_req.flags_in;
        o_cmd.wb    = 1'b1;
        o_cmd.msgn  = (opc == OP_IMUL);
        o_cmd.dzero = (bm == 16'h0000);
        o_cmd.qneg  = nneg ^ dneg;
        o_cmd.rneg  = nneg;
        o_cmd.dnum  = nneg ? (w ? neg32 : {16'h0000, negax}) : n32;
        o_cmd.dden  = dneg ? (w ? negb : {8'h00, negb8}) : bm;
        o_cmd.kind  = opc[2:0];
        o_cmd.cls   = CLS_BAD;

        if (opc inside {[OP_ADD:OP_CMP]}) begin
            o_cmd.cls = CLS_ALU;
            o_cmd.wb  = (opc != OP_CMP);
        end else if (opc == OP_TEST) begin
            o_cmd.cls  = CLS_ALU;
            o_cmd.kind = ALU_AND;
            o_cmd.wb   = 1'b0;
        end else if (opc inside {[OP_ROL:OP_SAR]}) begin
            o_cmd.cls  = CLS_SHIFT;
            o_cmd.kind = 3'(opc - OP_ROL);
        end else if (opc == OP_INC || opc == OP_DEC) begin
            o_cmd.cls  = CLS_INCDEC;
            o_cmd.kind = (opc == OP_INC) ? ALU_ADD : ALU_SUB;
            o_cmd.b    = 16'h0001;
        end else if (opc == OP_NEG) begin
            // Negation is a subtraction from zero.
            o_cmd.cls  = CLS_NEG;
            o_cmd.kind = ALU_SUB;
            o_cmd.a    = 16'h0000;
            o_cmd.b    = am;
        end else if (opc == OP_NOT) begin
            o_cmd.cls = CLS_NOT;
        end else if (opc == OP_MUL || opc == OP_IMUL) begin
            o_cmd.cls = CLS_MUL;
        end else if (opc == OP_DIV || opc == OP_IDIV) begin
            o_cmd.cls = CLS_DIV;
        end else begin
            o_cmd.wb = 1'b0;
        end
    end

endmodule

>>> sv/x86alu_queue.sv
`timescale 1ns / 1ps
// Small flip-flop queue that decouples the front end from the execute back end.
module x86alu_queue import x86alu_pkg::*; #(
    parameter int DEPTH = 4
) (
    input  logic i_clk,
    input  logic i_rst_n,
    input  logic i_wr,
    input  t_cmd i_wdata,
    output logic o_full,
    input  logic i_rd,
    output t_cmd o_rdata,
    output logic o_empty
);

    localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CNT_W = $clog2(DEPTH + 1);

    t_cmd             r_mem [DEPTH];
    logic [PTR_W-1:0] r_wr_ptr;
    logic [PTR_W-1:0] r_rd_ptr;
    logic [CNT_W-1:0] r_count;
    logic             wr_en;
    logic             rd_en;

    assign o_full  = (r_count == CNT_W'(DEPTH));
    assign o_empty = (r_count == '0);
    assign wr_en   = i_wr && !o_full;
    assign rd_en   = i_rd && !o_empty;
    assign o_rdata = r_mem[r_rd_ptr];

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_ptr <= '0;
            r_rd_ptr <= '0;
            r_count  <= '0;
        end else begin
            if (wr_en) begin
                r_wr_ptr <= (r_wr_ptr == PTR_W'(DEPTH - 1)) ? '0 : r_wr_ptr + 1'b1;
            end
            if (rd_en) begin
                r_rd_ptr <= (r_rd_ptr == PTR_W'(DEPTH - 1)) ? '0 : r_rd_ptr + 1'b1;
            end
            if (wr_en && !rd_en) begin
                r_count <= r_count + 1'b1;
            end else if (rd_en && !wr_en) begin
                r_count <= r_count - 1'b1;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (wr_en) begin
            r_mem[r_wr_ptr] <= i_wdata;
        end
    end

    a_count_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_count <= CNT_W'(DEPTH))
        else $error("queue count exceeds its depth");

endmodule

>>> sv/x86alu_div.sv
`timescale 1ns / 1ps
// Pipelined restoring divider: one quotient bit per stage, side data carried along.
module x86alu_div import x86alu_pkg::*; (
    input  logic  i_clk,
    input  logic  i_rst_n,
    input  logic  i_adv,
    input  logic  i_valid,
    input  t_side i_side,
    input  t_div  i_div,
    output logic  o_valid,
    output t_side o_side,
    output t_div  o_div
);

    logic  r_valid [DIV_STEPS];
    t_side r_side  [DIV_STEPS];
    t_div  r_div   [DIV_STEPS];

    function automatic t_div div_step(input t_div d);
        t_div        n;
        logic [16:0] sh;
        logic [16:0] diff;
        logic        ge;
        sh    = {d.rem, d.num[31]};
        diff  = sh - {1'b0, d.den};
        ge    = (sh >= {1'b0, d.den});
        n.rem = ge ? diff[15:0] : sh[15:0];
        n.num = {d.num[30:0], ge};
        n.den = d.den;
        return n;
    endfunction

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            for (int k = 0; k < DIV_STEPS; k++) begin
                r_valid[k] <= 1'b0;
            end
        end else if (i_adv) begin
            r_valid[0] <= i_valid;
            for (int k = 1; k < DIV_STEPS; k++) begin
                r_valid[k] <= r_valid[k-1];
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_adv) begin
            r_side[0] <= i_side;
            r_div[0]  <= div_step(i_div);
            for (int k = 1; k < DIV_STEPS; k++) begin
                r_side[k] <= r_side[k-1];
                r_div[k]  <= div_step(r_div[k-1]);
            end
        end
    end

    assign o_valid = r_valid[DIV_STEPS-1];
    assign o_side  = r_side[DIV_STEPS-1];
    assign o_div   = r_div[DIV_STEPS-1];

endmodule

>>> sv/x86alu_back.sv
`timescale 1ns / 1ps
// Back end: execute stage, divider pipeline, result finishing and output register.
module x86alu_back import x86alu_pkg::*; (
    input  logic      i_clk,
    input  logic      i_rst_n,
    input  logic      i_valid,
    input  t_cmd      i_cmd,
    output logic      o_take,
    input  logic      i_pop,
    output t_out_item o_res,
    output logic      o_empty
);

    logic        adv;
    logic        cin;
    logic [16:0] alu_sum;
    logic [15:0] alu_r;
    logic [15:0] alu_ov;
    logic        alu_sub;
    logic [15:0] alu_f;
    logic [3:0]  rw;
    logic [3:0]  m9;
    logic [4:0]  m17;
    logic [31:0] rl32;
    logic [31:0] rr32;
    logic [15:0] rl16;
    logic [15:0] rr16;
    logic [33:0] rc34;
    logic [33:0] rd34;
    logic [17:0] rc18;
    logic [17:0] rd18;
    logic [47:0] shl48;
    logic [16:0] shr17;
    logic [32:0] sar33;
    logic [15:0] sh_r;
    logic        sh_cf;
    logic        sh_of;
    logic        sh_top;
    logic [15:0] sh_f;
    logic [16:0] ma;
    logic [16:0] mb;
    logic [33:0] mprod;
    t_side       x_side;
    t_div        x_div;

    logic        r_x_valid;
    t_side       r_x_side;
    t_div        r_x_div;
    logic        d_valid;
    t_side       d_side;
    t_div        d_div;
    t_out_item   fin;
    logic        r_out_valid;
    t_out_item   r_out;

    function automatic logic [15:0] zsp(input logic [15:0] f, input logic [15:0] r,
                                        input logic w);
        logic [15:0] g;
        g          = f;
        g[FLAG_ZF] = w ? (r == 16'h0000) : (r[7:0] == 8'h00);
        g[FLAG_SF] = w ? r[15] : r[7];
        g[FLAG_PF] = ~^r[7:0];
        return g;
    endfunction

    // The whole back end moves together whenever the output slot can take a result.
    assign adv     = !r_out_valid || i_pop;
    assign o_take  = adv && i_valid;
    assign o_empty = !r_out_valid;
    assign o_res   = r_out;

    // Add, subtract and logic operations, also used by INC, DEC and NEG.
    always_comb begin
        cin = ((i_cmd.kind == ALU_ADC) || (i_cmd.kind == ALU_SBB)) ?
              i_cmd.flags[FLAG_CF] : 1'b0;
        case (i_cmd.kind)
            ALU_ADD, ALU_ADC: begin
                alu_sum = {1'b0, i_cmd.a} + {1'b0, i_cmd.b} + {16'h0000, cin};
            end
            ALU_SBB, ALU_SUB, ALU_CMP: begin
                alu_sum = {1'b0, i_cmd.a} - {1'b0, i_cmd.b} - {16'h0000, cin};
            end
            ALU_OR:  alu_sum = {1'b0, i_cmd.a | i_cmd.b};
            ALU_AND: alu_sum = {1'b0, i_cmd.a & i_cmd.b};
            default: alu_sum = {1'b0, i_cmd.a ^ i_cmd.b};
        endcase
        alu_r   = i_cmd.word ? alu_sum[15:0] : {8'h00, alu_sum[7:0]};
        alu_sub = (i_cmd.kind == ALU_SBB) || (i_cmd.kind == ALU_SUB) ||
                  (i_cmd.kind == ALU_CMP);
        alu_ov  = alu_sub ? ((i_cmd.a ^ i_cmd.b) & (i_cmd.a ^ alu_r)) :
                            (~(i_cmd.a ^ i_cmd.b) & (i_cmd.a ^ alu_r));
        alu_f   = i_cmd.flags;
        if ((i_cmd.kind == ALU_OR) || (i_cmd.kind == ALU_AND) || (i_cmd.kind == ALU_XOR)) begin
            alu_f[FLAG_CF] = 1'b0;
            alu_f[FLAG_OF] = 1'b0;
            alu_f[FLAG_AF] = 1'b0;
        end else begin
            alu_f[FLAG_CF] = i_cmd.word ? alu_sum[16] : alu_sum[8];
            alu_f[FLAG_AF] = (i_cmd.a[4] ^ i_cmd.b[4] ^ alu_r[4]);
            alu_f[FLAG_OF] = i_cmd.word ? alu_ov[15] : alu_ov[7];
        end
        alu_f = zsp(alu_f, alu_r, i_cmd.word);
        if (i_cmd.cls == CLS_INCDEC) begin
            alu_f[FLAG_CF] = i_cmd.flags[FLAG_CF];
        end
    end

    // Shifts and rotates in closed form; a rotate count is reduced modulo the rotate width.
    always_comb begin
        rw = i_cmd.word ? i_cmd.cnt[3:0] : {1'b0, i_cmd.cnt[2:0]};
        if (i_cmd.cnt >= 5'd27) begin
            m9 = 4'(i_cmd.cnt - 5'd27);
        end else if (i_cmd.cnt >= 5'd18) begin
            m9 = 4'(i_cmd.cnt - 5'd18);
        end else if (i_cmd.cnt >= 5'd9) begin
            m9 = 4'(i_cmd.cnt - 5'd9);
        end else begin
            m9 = i_cmd.cnt[3:0];
        end
        m17   = (i_cmd.cnt >= 5'd17) ? (i_cmd.cnt - 5'd17) : i_cmd.cnt;
        rl32  = {i_cmd.a, i_cmd.a} << rw;
        rr32  = {i_cmd.a, i_cmd.a} >> rw;
        rl16  = {i_cmd.a[7:0], i_cmd.a[7:0]} << rw;
        rr16  = {i_cmd.a[7:0], i_cmd.a[7:0]} >> rw;
        rc34  = {i_cmd.flags[FLAG_CF], i_cmd.a, i_cmd.flags[FLAG_CF], i_cmd.a} << m17;
        rd34  = {i_cmd.flags[FLAG_CF], i_cmd.a, i_cmd.flags[FLAG_CF], i_cmd.a} >> m17;
        rc18  = {i_cmd.flags[FLAG_CF], i_cmd.a[7:0], i_cmd.flags[FLAG_CF], i_cmd.a[7:0]} << m9;
        rd18  = {i_cmd.flags[FLAG_CF], i_cmd.a[7:0], i_cmd.flags[FLAG_CF], i_cmd.a[7:0]} >> m9;
        shl48 = {32'h0000_0000, i_cmd.a} << i_cmd.cnt;
        shr17 = {i_cmd.a, 1'b0} >> i_cmd.cnt;
        sar33 = i_cmd.word ? {{16{i_cmd.a[15]}}, i_cmd.a, 1'b0} :
                             {{24{i_cmd.a[7]}}, i_cmd.a[7:0], 1'b0};
        sar33 = 33'($signed(sar33) >>> i_cmd.cnt);

        case (i_cmd.kind)
            SH_ROL: begin
                sh_r  = i_cmd.word ? rl32[31:16] : {8'h00, rl16[15:8]};
                sh_cf = sh_r[0];
            end
            SH_ROR: begin
                sh_r  = i_cmd.word ? rr32[15:0] : {8'h00, rr16[7:0]};
                sh_cf = i_cmd.word ? sh_r[15] : sh_r[7];
            end
            SH_RCL: begin
                sh_r  = i_cmd.word ? rc34[32:17] : {8'h00, rc18[16:9]};
                sh_cf = i_cmd.word ? rc34[33] : rc18[17];
            end
            SH_RCR: begin
                sh_r  = i_cmd.word ? rd34[15:0] : {8'h00, rd18[7:0]};
                sh_cf = i_cmd.word ? rd34[16] : rd18[8];
            end
            SH_SHL, SH_SAL: begin
                sh_r  = i_cmd.word ? shl48[15:0] : {8'h00, shl48[7:0]};
                sh_cf = i_cmd.word ? shl48[16] : shl48[8];
            end
            SH_SHR: begin
                sh_r  = shr17[16:1];
                sh_cf = shr17[0];
            end
            default: begin
                sh_r  = i_cmd.word ? sar33[16:1] : {8'h00, sar33[8:1]};
                sh_cf = sar33[0];
            end
        endcase

        sh_top = i_cmd.word ? sh_r[15] : sh_r[7];
        case (i_cmd.kind)
            SH_ROR, SH_RCR: sh_of = sh_top ^ (i_cmd.word ? sh_r[14] : sh_r[6]);
            SH_SHR:         sh_of = (i_cmd.cnt == 5'd1) &&
                                    (i_cmd.word ? i_cmd.a[15] : i_cmd.a[7]);
            SH_SAR:         sh_of = 1'b0;
            default:        sh_of = sh_top ^ sh_cf;
        endcase

        sh_f = i_cmd.flags;
        if (i_cmd.cnt != 5'd0) begin
            sh_f[FLAG_CF] = sh_cf;
            sh_f[FLAG_OF] = sh_of;
            if (i_cmd.kind[2]) begin
                sh_f = zsp(sh_f, sh_r, i_cmd.word);
            end
        end
    end

    // Execute stage selection; multiply and divide are finished at the end of the pipe.
    always_comb begin
        ma = i_cmd.msgn ? (i_cmd.word ? {i_cmd.a[15], i_cmd.a} : {{9{i_cmd.a[7]}}, i_cmd.a[7:0]})
                        : {1'b0, i_cmd.a};
        mb = i_cmd.msgn ? (i_cmd.word ? {i_cmd.b[15], i_cmd.b} : {{9{i_cmd.b[7]}}, i_cmd.b[7:0]})
                        : {1'b0, i_cmd.b};
        mprod = 34'($signed(ma) * $signed(mb));

        x_side       = '0;
        x_side.cls   = i_cmd.cls;
        x_side.word  = i_cmd.word;
        x_side.msgn  = i_cmd.msgn;
        x_side.qneg  = i_cmd.qneg;
        x_side.rneg  = i_cmd.rneg;
        x_side.wb    = i_cmd.wb;
        x_side.flags = i_cmd.flags;
        x_side.prod  = mprod[31:0];
        case (i_cmd.cls)
            CLS_ALU, CLS_INCDEC, CLS_NEG: begin
                x_side.res   = alu_r;
                x_side.flags = alu_f;
            end
            CLS_SHIFT: begin
                x_side.res   = sh_r;
                x_side.flags = sh_f;
            end
            CLS_NOT: begin
                x_side.res = i_cmd.word ? ~i_cmd.a : {8'h00, ~i_cmd.a[7:0]};
            end
            CLS_DIV: begin
                if (i_cmd.dzero) begin
                    x_side.fault = 1'b1;
                    x_side.wb    = 1'b0;
                    x_side.res   = i_cmd.ax;
                    x_side.hi    = i_cmd.dx;
                end
            end
            default: begin
                x_side.res = 16'h0000;
            end
        endcase

        x_div.rem = 16'h0000;
        x_div.num = i_cmd.dnum;
        x_div.den = i_cmd.dden;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_x_valid <= 1'b0;
        end else if (adv) begin
            r_x_valid <= i_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (adv) begin
            r_x_side <= x_side;
            r_x_div  <= x_div;
        end
    end

    x86alu_div u_div (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_adv   (adv),
        .i_valid (r_x_valid),
        .i_side  (r_x_side),
        .i_div   (r_x_div),
        .o_valid (d_valid),
        .o_side  (d_side),
        .o_div   (d_div)
    );

    // Multiply overflow, divide sign correction and final result selection.
    always_comb begin
        logic        over;
        logic [31:0] q;
        logic [15:0] r;
        q = d_side.qneg ? (32'd0 - d_div.num) : d_div.num;
        r = d_side.rneg ? (16'd0 - d_div.rem) : d_div.rem;
        if (d_side.msgn) begin
            over = d_side.word ?
                   !((&d_side.prod[31:15]) || !(|d_side.prod[31:15])) :
                   !((&d_side.prod[15:7]) || !(|d_side.prod[15:7]));
        end else begin
            over = d_side.word ? (d_side.prod[31:16] != 16'h0000) :
                                 (d_side.prod[15:8] != 8'h00);
        end

        fin.result       = d_side.res;
        fin.result_high  = d_side.hi;
        fin.flags_out    = d_side.flags;
        fin.divide_fault = d_side.fault;
        fin.write_back   = d_side.wb;
        if (d_side.cls == CLS_MUL) begin
            fin.result             = d_side.prod[15:0];
            fin.result_high        = d_side.word ? d_side.prod[31:16] : 16'h0000;
            fin.flags_out[FLAG_CF] = over;
            fin.flags_out[FLAG_OF] = over;
        end else if ((d_side.cls == CLS_DIV) && !d_side.fault) begin
            fin.result      = d_side.word ? q[15:0] : {8'h00, q[7:0]};
            fin.result_high = d_side.word ? r : {8'h00, r[7:0]};
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (adv) begin
            r_out_valid <= d_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (adv) begin
            r_out <= fin;
        end
    end

    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_out_valid && !i_pop |=> r_out_valid && $stable(r_out))
        else $error("waiting result changed while stalled");

    a_fault_no_wb: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_out_valid && r_out.divide_fault |-> !r_out.write_back)
        else $error("faulting divide marked for write-back");

    a_drain: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        adv && d_valid |=> r_out_valid)
        else $error("result leaving the divider pipe was lost");

endmodule

>>> sim/x86_16bit_alu_flags_core_tb.sv
`timescale 1ns / 1ps
// Self-checking testbench for the 16-bit x86 ALU with flags.
module x86_16bit_alu_flags_core_tb;
    import x86alu_pkg::*;

    localparam int N_RANDOM = 750;
    localparam int CYCLE_LIMIT = 200000;

    // Operation codes with no meaning; they must come back as a no-op.
    localparam logic [4:0] OP_UNK_FIRST = 5'd25;
    localparam logic [4:0] OP_UNK_LAST  = 5'd27;

    typedef struct {
        t_in_item  req;
        logic      has_res;
        t_out_item res;
    } t_row;

    logic      i_clk;
    logic      i_rst_n;
    logic      push;
    logic      full;
    t_in_item  i_req;
    logic      empty;
    logic      pop;
    t_out_item o_res;

    t_out_item expected_q[$];
    int        err_count;
    int        results_seen;
    int        cycle_count;
    int        fault_count;
    logic [24:0] ops_seen;

    x86_16bit_alu_flags_core uut (
        .i_clk  (i_clk),
        .i_rst_n(i_rst_n),
        .push   (push),
        .full   (full),
        .i_req  (i_req),
        .empty  (empty),
        .pop    (pop),
        .o_res  (o_res)
    );

    always begin
        i_clk = 1'b1;
        #4;
        i_clk = 1'b0;
        #4;
    end

    function automatic logic [15:0] set_bit(logic [15:0] f, int pos, logic v);
        f[pos] = v;
        return f;
    endfunction

    function automatic logic [15:0] zsp_flags(logic [15:0] f, logic [15:0] r, logic wd);
        logic [15:0] m;
        begin
            m = wd ? 16'hFFFF : 16'h00FF;
            f = set_bit(f, FLAG_ZF, (r & m) == 16'd0);
            f = set_bit(f, FLAG_SF, wd ? r[15] : r[7]);
            f = set_bit(f, FLAG_PF, ~^r[7:0]);
            return f;
        end
    endfunction

    // Add/subtract/logic core shared by the ALU group, INC, DEC and NEG.
    function automatic logic [15:0] arith(logic [2:0] kind, logic [15:0] a, logic [15:0] b,
                                          logic wd, inout logic [15:0] f);
        logic [16:0] full_r;
        logic [15:0] r, m, ov;
        logic        sub;
        begin
            m = wd ? 16'hFFFF : 16'h00FF;
            case (kind)
                ALU_ADD: full_r = a + b;
                ALU_ADC: full_r = a + b + f[FLAG_CF];
                ALU_SBB: full_r = {1'b0, a} - {1'b0, b} - f[FLAG_CF];
                ALU_SUB, ALU_CMP: full_r = {1'b0, a} - {1'b0, b};
                ALU_OR: full_r = {1'b0, a | b};
                ALU_AND: full_r = {1'b0, a & b};
                default: full_r = {1'b0, a ^ b};
            endcase
            r = full_r[15:0] & m;
            if (kind == ALU_OR || kind == ALU_AND || kind == ALU_XOR) begin
                f[FLAG_CF] = 1'b0;
                f[FLAG_OF] = 1'b0;
                f[FLAG_AF] = 1'b0;
            end else begin
                sub = (kind == ALU_SBB || kind == ALU_SUB || kind == ALU_CMP);
                ov = sub ? ((a ^ b) & (a ^ r)) : (~(a ^ b) & (a ^ r));
                // Borrow or carry out of the operand width.
                f[FLAG_CF] = wd ? full_r[16] : full_r[8];
                f[FLAG_AF] = a[4] ^ b[4] ^ r[4];
                f[FLAG_OF] = wd ? ov[15] : ov[7];
            end
            f = zsp_flags(f, r, wd);
            return r;
        end
    endfunction

    function automatic t_out_item alu_predict(t_in_item q);
        t_out_item   o;
        logic [15:0] m, msb, a, b, f, val, prev;
        logic [4:0]  cnt;
        logic [2:0]  kind;
        logic        cf, top, low, over, keep, nneg, dneg;
        logic [31:0] p, n, un, uq, ur;
        logic [15:0] ud;
        int          sa, sb, sp;
        begin
            m = q.word_size ? 16'hFFFF : 16'h00FF;
            msb = q.word_size ? 16'h8000 : 16'h0080;
            a = q.operand_a & m;
            b = q.operand_b & m;
            cnt = q.shift_count[4:0];
            f = q.flags_in;
            o = '0;
            o.write_back = 1'b1;
            if (q.operation <= OP_TEST) begin
                kind = (q.operation == OP_TEST) ? ALU_AND : q.operation[2:0];
                o.result = arith(kind, a, b, q.word_size, f);
                if (q.operation == OP_CMP || q.operation == OP_TEST) o.write_back = 1'b0;
            end else if (q.operation <= OP_SAR) begin
                kind = 3'(q.operation - OP_ROL);
                val = a;
                prev = a;
                cf = f[FLAG_CF];
                for (int k = 0; k < cnt; k++) begin
                    top = (val & msb) != 0;
                    low = val[0];
                    prev = val;
                    case (kind)
                        SH_ROL: begin val = ((val << 1) | top) & m; cf = top; end
                        SH_ROR: begin
                            val = ((val >> 1) | (low ? msb : 16'h0000)) & m;
                            cf = low;
                        end
                        SH_RCL: begin val = ((val << 1) | cf) & m; cf = top; end
                        SH_RCR: begin
                            val = ((val >> 1) | (cf ? msb : 16'h0000)) & m;
                            cf = low;
                        end
                        SH_SHL, SH_SAL: begin val = (val << 1) & m; cf = top; end
                        SH_SHR: begin val = val >> 1; cf = low; end
                        default: begin val = (val >> 1) | (val & msb); cf = low; end
                    endcase
                end
                o.result = val;
                if (cnt != 0) begin
                    f[FLAG_CF] = cf;
                    if (kind == SH_ROR || kind == SH_RCR)
                        f[FLAG_OF] = ((val & msb) != 0) ^ ((val & (msb >> 1)) != 0);
                    else if (kind == SH_SHR)
                        f[FLAG_OF] = (prev & msb) != 0;
                    else if (kind == SH_SAR)
                        f[FLAG_OF] = 1'b0;
                    else
                        f[FLAG_OF] = ((val & msb) != 0) ^ cf;
                    if (kind >= SH_SHL) f = zsp_flags(f, val, q.word_size);
                end
            end else if (q.operation == OP_INC || q.operation == OP_DEC) begin
                keep = f[FLAG_CF];
                o.result = arith(q.operation == OP_INC ? ALU_ADD : ALU_SUB, a, 16'd1,
                                 q.word_size, f);
                f[FLAG_CF] = keep;
            end else if (q.operation == OP_NEG) begin
                o.result = arith(ALU_SUB, 16'd0, a, q.word_size, f);
                f[FLAG_CF] = a != 0;
            end else if (q.operation == OP_NOT) begin
                o.result = ~a & m;
            end else if (q.operation == OP_MUL) begin
                p = a * b;
                o.result = p[15:0];
                if (q.word_size) begin
                    o.result_high = p[31:16];
                    over = p[31:16] != 0;
                end else begin
                    over = p[15:8] != 0;
                end
                f[FLAG_CF] = over;
                f[FLAG_OF] = over;
            end else if (q.operation == OP_IMUL) begin
                sa = q.word_size ? int'($signed(a)) : int'($signed(a[7:0]));
                sb = q.word_size ? int'($signed(b)) : int'($signed(b[7:0]));
                sp = sa * sb;
                o.result = sp[15:0];
                if (q.word_size) begin
                    o.result_high = sp[31:16];
                    over = sp < -32768 || sp > 32767;
                end else begin
                    over = sp < -128 || sp > 127;
                end
                f[FLAG_CF] = over;
                f[FLAG_OF] = over;
            end else if (q.operation == OP_DIV || q.operation == OP_IDIV) begin
                if (b == 0) begin
                    o.divide_fault = 1'b1;
                    o.write_back = 1'b0;
                    o.result = q.operand_a;
                    o.result_high = q.dividend_high;
                end else begin
                    n = q.word_size ? {q.dividend_high, q.operand_a} : {16'd0, q.operand_a};
                    if (q.operation == OP_DIV) begin
                        uq = n / b;
                        ur = n % b;
                    end else begin
                        // Sign-magnitude divide: truncate toward zero, remainder follows dividend.
                        nneg = q.word_size ? n[31] : n[15];
                        dneg = (b & msb) != 0;
                        un = nneg ? (32'd0 - n) : n;
                        if (!q.word_size) un = un & 32'hFFFF;
                        ud = dneg ? ((16'd0 - b) & m) : b;
                        uq = un / ud;
                        ur = un % ud;
                        if (nneg != dneg) uq = 32'd0 - uq;
                        if (nneg) ur = 32'd0 - ur;
                    end
                    o.result = uq[15:0] & m;
                    o.result_high = ur[15:0] & m;
                end
            end else begin
                o.write_back = 1'b0;
            end
            o.flags_out = f;
            return o;
        end
    endfunction

    function automatic t_in_item make_req(logic [4:0] op, logic wd, logic [15:0] a,
                                          logic [15:0] b, logic [15:0] dx, logic [7:0] sc,
                                          logic [15:0] fl);
        t_in_item q;
        begin
            q.operation = op;
            q.word_size = wd;
            q.operand_a = a;
            q.operand_b = b;
            q.dividend_high = dx;
            q.shift_count = sc;
            q.flags_in = fl;
            return q;
        end
    endfunction

    // Mostly valid codes, a few unknown ones, zero divisors and dividend high halves near the divisor.
    function automatic t_in_item random_req();
        t_in_item q;
        int       sel;
        begin
            q = t_in_item'({$urandom, $urandom, $urandom});
            sel = $urandom_range(0, 99);
            q.operation = (sel < 96) ? 5'($urandom_range(0, OP_IDIV)) :
                                       5'($urandom_range(OP_UNK_FIRST, OP_UNK_LAST));
            if ($urandom_range(0, 3) == 0) q.shift_count[4:0] = 5'($urandom_range(0, 2));
            if (q.operation == OP_DIV || q.operation == OP_IDIV) begin
                sel = $urandom_range(0, 9);
                if (sel == 0) q.operand_b = 16'd0;
                else if (sel < 4) q.dividend_high = q.operand_b & 16'h7FFF;
            end
            return q;
        end
    endfunction

    // Called at a falling edge; returns at the falling edge after the accepting edge,
    // leaving push high so that a following request can go out with no gap.
    task automatic send_req(t_in_item q);
        int gap;
        begin
            gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(0, 15);
            if (gap > 0) begin
                push <= 1'b0;
                repeat (gap) @(negedge i_clk);
            end
            i_req <= q;
            push <= 1'b1;
            @(posedge i_clk);
            while (full) @(posedge i_clk);
            expected_q.push_back(alu_predict(q));
            if (q.operation <= OP_IDIV) ops_seen[q.operation] = 1'b1;
            @(negedge i_clk);
        end
    endtask

    // Result side: random stalls, checks each popped result against the oldest expectation.
    initial begin
        int        stall;
        t_out_item exp_r;
        pop = 1'b0;
        @(posedge i_rst_n);
        forever begin
            @(negedge i_clk);
            stall = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(0, 15);
            if (stall > 0) begin
                pop <= 1'b0;
                repeat (stall) @(negedge i_clk);
            end
            pop <= 1'b1;
            @(posedge i_clk);
            while (empty) @(posedge i_clk);
            if (expected_q.size() == 0) begin
                $error("result with no request outstanding: %h", o_res);
                err_count++;
            end else begin
                exp_r = expected_q.pop_front();
                results_seen++;
                if (o_res.divide_fault) fault_count++;
                if (o_res.result !== exp_r.result) begin
                    $error("result exp %h got %h", exp_r.result, o_res.result);
                    err_count++;
                end
                if (o_res.result_high !== exp_r.result_high) begin
                    $error("result_high exp %h got %h", exp_r.result_high, o_res.result_high);
                    err_count++;
                end
                if (o_res.flags_out !== exp_r.flags_out) begin
                    $error("flags_out exp %h got %h", exp_r.flags_out, o_res.flags_out);
                    err_count++;
                end
                if (o_res.divide_fault !== exp_r.divide_fault) begin
                    $error("divide_fault exp %b got %b", exp_r.divide_fault, o_res.divide_fault);
                    err_count++;
                end
                if (o_res.write_back !== exp_r.write_back) begin
                    $error("write_back exp %b got %b", exp_r.write_back, o_res.write_back);
                    err_count++;
                end
            end
        end
    end

    always @(posedge i_clk) begin
        cycle_count <= cycle_count + 1;
        if (cycle_count > CYCLE_LIMIT) begin
            $display("timeout after %0d cycles", cycle_count);
            $display("DONE: errors detected");
            $finish;
        end
    end

    initial begin
        t_row directed[$];
        t_row row;
        t_out_item typed;
        int drain;
        err_count = 0;
        results_seen = 0;
        fault_count = 0;
        cycle_count = 0;
        ops_seen = '0;
        push = 1'b0;
        i_req = '0;
        i_rst_n = 1'b0;

        // Rows with a hand-written expectation are checked against it as well.
        typed = '{result: 16'h0000, result_high: 16'h0000, flags_out: 16'h0055,
                  divide_fault: 1'b0, write_back: 1'b1};
        directed.push_back('{make_req(OP_ADD, 1'b1, 16'hFFFF, 16'h0001, 16'h0, 8'h0, 16'h0000),
                             1'b1, typed});
        typed = '{result: 16'h1234, result_high: 16'hABCD, flags_out: 16'h0FFF,
                  divide_fault: 1'b1, write_back: 1'b0};
        directed.push_back('{make_req(OP_DIV, 1'b1, 16'h1234, 16'h0000, 16'hABCD, 8'h0,
                                      16'h0FFF), 1'b1, typed});
        typed = '{result: 16'h00AA, result_high: 16'h0000, flags_out: 16'h0000,
                  divide_fault: 1'b1, write_back: 1'b0};
        directed.push_back('{make_req(OP_IDIV, 1'b0, 16'h00AA, 16'hFF00, 16'h0, 8'h0,
                                      16'h0000), 1'b1, typed});
        typed = '{result: 16'h0000, result_high: 16'h0000, flags_out: 16'hFFFF,
                  divide_fault: 1'b0, write_back: 1'b0};
        directed.push_back('{make_req(OP_UNK_LAST, 1'b1, 16'hFFFF, 16'hFFFF, 16'hFFFF, 8'hFF,
                                      16'hFFFF), 1'b1, typed});
        directed.push_back('{make_req(OP_ADC, 1'b0, 16'h00FF, 16'h0000, 16'h0, 8'h0, 16'h0001),
                             1'b0, '0});
        directed.push_back('{make_req(OP_SBB, 1'b1, 16'h0000, 16'hFFFF, 16'h0, 8'h0, 16'h0001),
                             1'b0, '0});
        directed.push_back('{make_req(OP_SUB, 1'b0, 16'h0080, 16'h0001, 16'h0, 8'h0, 16'h0000),
                             1'b0, '0});
        directed.push_back('{make_req(OP_OR, 1'b1, 16'h8000, 16'h0001, 16'h0, 8'h0, 16'h0811),
                             1'b0, '0});
        directed.push_back('{make_req(OP_XOR, 1'b0, 16'h1234, 16'h0034, 16'h0, 8'h0, 16'hFFFF),
                             1'b0, '0});
        directed.push_back('{make_req(OP_CMP, 1'b1, 16'h7FFF, 16'h8000, 16'h0, 8'h0, 16'h0000),
                             1'b0, '0});
        directed.push_back('{make_req(OP_TEST, 1'b0, 16'hFFFF, 16'h00F0, 16'h0, 8'h0, 16'h0811),
                             1'b0, '0});
        directed.push_back('{make_req(OP_INC, 1'b0, 16'h007F, 16'h0, 16'h0, 8'h0, 16'h0001),
                             1'b0, '0});
        directed.push_back('{make_req(OP_DEC, 1'b1, 16'h8000, 16'h0, 16'h0, 8'h0, 16'h0000),
                             1'b0, '0});
        directed.push_back('{make_req(OP_NEG, 1'b1, 16'h8000, 16'h0, 16'h0, 8'h0, 16'h0000),
                             1'b0, '0});
        directed.push_back('{make_req(OP_NEG, 1'b0, 16'h0000, 16'h0, 16'h0, 8'h0, 16'h0001),
                             1'b0, '0});
        directed.push_back('{make_req(OP_NOT, 1'b1, 16'h5A5A, 16'h0, 16'h0, 8'h0, 16'h0AD5),
                             1'b0, '0});
        directed.push_back('{make_req(OP_ROL, 1'b1, 16'h8001, 16'h0, 16'h0, 8'hE0, 16'h0801),
                             1'b0, '0});
        directed.push_back('{make_req(OP_RCR, 1'b0, 16'h0081, 16'h0, 16'h0, 8'h1F, 16'h0001),
                             1'b0, '0});
        directed.push_back('{make_req(OP_SAR, 1'b1, 16'h8000, 16'h0, 16'h0, 8'h11, 16'h0000),
                             1'b0, '0});
        directed.push_back('{make_req(OP_SHR, 1'b0, 16'h00C0, 16'h0, 16'h0, 8'h01, 16'h0010),
                             1'b0, '0});
        directed.push_back('{make_req(OP_MUL, 1'b1, 16'hFFFF, 16'hFFFF, 16'h0, 8'h0, 16'h0000),
                             1'b0, '0});
        directed.push_back('{make_req(OP_IMUL, 1'b0, 16'h0080, 16'h0080, 16'h0, 8'h0, 16'h0000),
                             1'b0, '0});
        directed.push_back('{make_req(OP_IMUL, 1'b1, 16'h8000, 16'hFFFF, 16'h0, 8'h0, 16'h0000),
                             1'b0, '0});
        directed.push_back('{make_req(OP_DIV, 1'b1, 16'hFFFF, 16'h0001, 16'hFFFF, 8'h0,
                                      16'h0000), 1'b0, '0});
        directed.push_back('{make_req(OP_IDIV, 1'b1, 16'h0000, 16'hFFFF, 16'h8000, 8'h0,
                                      16'h0000), 1'b0, '0});

        repeat (10) @(negedge i_clk);
        i_rst_n <= 1'b1;

        foreach (directed[i]) begin
            row = directed[i];
            if (row.has_res && alu_predict(row.req) !== row.res) begin
                $error("directed row %0d: predictor exp %h, table %h", i,
                       alu_predict(row.req), row.res);
                err_count++;
            end
            send_req(row.req);
        end
        repeat (N_RANDOM) send_req(random_req());
        push <= 1'b0;

        while (expected_q.size() != 0) @(posedge i_clk);
        drain = 0;
        while (drain < 60) begin
            @(posedge i_clk);
            drain++;
        end
        $display("Checked %0d results over %0d ALU operation codes, %0d divide faults.",
                 results_seen, $countones(ops_seen), fault_count);
        if (err_count == 0) begin
            $display("DONE: 0 errors");
        end else begin
            $display("DONE: errors detected");
        end
        $finish;
    end

endmodule

>>> files.f
sv/x86alu_pkg.sv
sv/x86alu_front.sv
sv/x86alu_queue.sv
sv/x86alu_div.sv
sv/x86alu_back.sv
sv/x86_16bit_alu_flags_core.sv
sim/x86_16bit_alu_flags_core_tb.sv
